// ===== design/kpd_pkg.sv =====
package kpd_pkg;

  // fixed field widths
  localparam int SampleW = 8;
  localparam int CodeW   = 4;
  localparam int CountW  = 8;

  // configuration register indexes
  localparam int CfgIndexW = 2;
  localparam logic [CfgIndexW-1:0] RegLongLimit  = 2'd0;
  localparam logic [CfgIndexW-1:0] RegIdleCode   = 2'd1;
  localparam logic [CfgIndexW-1:0] RegLongEnable = 2'd2;
  localparam int CfgDataW = 8;

  // register reset values
  localparam logic [CountW-1:0] LongLimitReset  = 8'd50;
  localparam logic [CodeW-1:0]  IdleCodeReset   = 4'd5;
  localparam logic              LongEnableReset = 1'b1;

  // code queue between front and back
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = 1;
  localparam int QueueCntW  = 2;

  // event kinds
  localparam logic EventShort = 1'b0;
  localparam logic EventLong  = 1'b1;

  typedef struct packed {
    logic [CountW-1:0] long_press_limit;
    logic [CodeW-1:0]  idle_code;
    logic              long_press_enable;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

endpackage

// ===== design/kpd_front.sv =====
module kpd_front #(
  parameter int KEYS = 4
) (
  input  logic                        in_valid,
  input  logic [kpd_pkg::SampleW-1:0] adc_sample,
  input  logic                        queue_full,
  output logic                        in_stall,
  output logic                        push,
  output logic [kpd_pkg::CodeW-1:0]   code
);

  localparam int Levels = KEYS + 1;
  localparam int Step   = 255 / Levels;
  localparam int Half   = Step / 2;

  logic [8:0] sample_ext;

  assign sample_ext = {1'b0, adc_sample};

  // first matching level window, else the out-of-range code
  always_comb begin
    code = kpd_pkg::CodeW'(KEYS + 2);
    for (int k = Levels; k >= 1; k--) begin
      if (sample_ext > 9'(Step * k - Half) && sample_ext < 9'(Step * k + Half)) begin
        code = kpd_pkg::CodeW'(k);
      end
    end
  end

  // hand classified codes to the queue
  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

endmodule

// ===== design/kpd_queue.sv =====
module kpd_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic [kpd_pkg::CodeW-1:0] push_code,
  input  logic                      pop,
  output kpd_pkg::queue_status_t    status,
  output logic [kpd_pkg::CodeW-1:0] head_code
);

  logic [kpd_pkg::CodeW-1:0]     entries [kpd_pkg::QueueDepth];
  logic [kpd_pkg::QueuePtrW-1:0] wr_ptr;
  logic [kpd_pkg::QueuePtrW-1:0] rd_ptr;
  logic [kpd_pkg::QueueCntW-1:0] count;

  assign status.full  = (count == kpd_pkg::QueueCntW'(kpd_pkg::QueueDepth));
  assign status.valid = (count != '0);
  assign head_code    = entries[rd_ptr];

  // pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_code;
    end
  end

endmodule

// ===== design/kpd_back.sv =====
module kpd_back (
  input  logic                      clk,
  input  logic                      rst,
  input  kpd_pkg::cfg_t             cfg,
  input  logic                      head_valid,
  input  logic [kpd_pkg::CodeW-1:0] head_code,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      long_event,
  output logic [kpd_pkg::CodeW-1:0] key_code
);

  logic [kpd_pkg::CodeW-1:0]  current_key;
  logic [kpd_pkg::CodeW-1:0]  current_key_next;
  logic                       long_flag;
  logic                       long_flag_next;
  logic [kpd_pkg::CountW-1:0] hold_count;
  logic [kpd_pkg::CountW-1:0] hold_count_next;
  logic                       emit;
  logic                       emit_kind;

  // take the next code once the output register is free or draining
  assign pop = head_valid && (!out_valid || !out_stall);

  // key tracking and event decision
  always_comb begin
    current_key_next = current_key;
    long_flag_next   = long_flag;
    hold_count_next  = hold_count + 1'b1;
    emit             = 1'b0;
    emit_kind        = kpd_pkg::EventShort;
    if (head_code == current_key) begin
      if (hold_count > cfg.long_press_limit && current_key != cfg.idle_code) begin
        emit            = cfg.long_press_enable;
        emit_kind       = kpd_pkg::EventLong;
        long_flag_next  = 1'b1;
        hold_count_next = '0;
      end
    end else begin
      emit             = (current_key != cfg.idle_code) && !long_flag;
      hold_count_next  = '0;
      current_key_next = head_code;
      long_flag_next   = 1'b0;
    end
  end

  // key state
  always_ff @(posedge clk) begin
    if (rst) begin
      current_key <= kpd_pkg::IdleCodeReset;
      long_flag   <= 1'b0;
      hold_count  <= '0;
    end else if (pop) begin
      current_key <= current_key_next;
      long_flag   <= long_flag_next;
      hold_count  <= hold_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      long_event <= emit_kind;
      key_code   <= current_key;
    end
  end

endmodule

// ===== design/adc_ladder_key_press_detector.sv =====
// a sample's code is registered in the code queue, then its result in the output register
// throughput: one sample per cycle while in_stall is low
// a two-entry code queue decouples sample classification from event output
// reset (synchronous, active high) loads register defaults, idle current key,
// cleared long flag and hold counter, and an empty queue and output
module adc_ladder_key_press_detector #(
  parameter int KEYS = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [kpd_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [kpd_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [kpd_pkg::SampleW-1:0]   adc_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          long_event,
  output logic [kpd_pkg::CodeW-1:0]     key_code
);

  kpd_pkg::cfg_t          cfg;
  kpd_pkg::queue_status_t q_status;
  logic                   push;
  logic                   pop;
  logic [kpd_pkg::CodeW-1:0] front_code;
  logic [kpd_pkg::CodeW-1:0] head_code;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_limit  <= kpd_pkg::LongLimitReset;
      cfg.idle_code         <= kpd_pkg::IdleCodeReset;
      cfg.long_press_enable <= kpd_pkg::LongEnableReset;
    end else if (cfg_write) begin
      case (cfg_index)
        kpd_pkg::RegLongLimit:  cfg.long_press_limit  <= cfg_data;
        kpd_pkg::RegIdleCode:   cfg.idle_code         <= cfg_data[kpd_pkg::CodeW-1:0];
        kpd_pkg::RegLongEnable: cfg.long_press_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  kpd_front #(
    .KEYS(KEYS)
  ) u_front (
    .in_valid  (in_valid),
    .adc_sample(adc_sample),
    .queue_full(q_status.full),
    .in_stall  (in_stall),
    .push      (push),
    .code      (front_code)
  );

  kpd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_code(front_code),
    .pop      (pop),
    .status   (q_status),
    .head_code(head_code)
  );

  kpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head_valid(q_status.valid),
    .head_code (head_code),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .long_event(long_event),
    .key_code  (key_code)
  );

endmodule
